/* rtl/core/blss_pkg.sv */
// ----------------------------------------------------------------------------
// blss_pkg
// Shared types and constants for the band-limited step synthesizer.
// ----------------------------------------------------------------------------
package blss_pkg;

  localparam int TAPS_DEF        = 64;
  localparam int PHASES_DEF      = 64;
  localparam int BUF_SAMPLES_DEF = 2048;
  localparam int RING_DEPTH_DEF  = BUF_SAMPLES_DEF + TAPS_DEF;

  localparam int COEF_DEPTH = 4096;
  localparam int COEF_AW    = 12;

  localparam logic [1:0] OP_WR_COEF = 2'd0;
  localparam logic [1:0] OP_PUSH    = 2'd1;
  localparam logic [1:0] OP_READ    = 2'd2;

  localparam logic [31:0] ROUND_HALF = 32'h0000_4000;
  localparam logic [15:0] SAT_POS    = 16'h7fff;
  localparam logic [15:0] SAT_NEG    = 16'h8000;
  localparam logic [31:0] SAT_POS_SUM = 32'h3fff_8000;
  localparam logic [31:0] SAT_NEG_SUM = 32'hc000_0000;
  localparam int LEAK_SHIFT  = 9;
  localparam int OUT_SHIFT   = 15;

  typedef struct packed {
    logic [1:0]         opcode;
    logic signed [15:0] sample_in;
    logic [11:0]        coef_index;
    logic signed [15:0] coef_value;
  } blss_in_t;

  typedef struct packed {
    logic signed [15:0] sample_out;
    logic [11:0]        avail_count;
    logic               overflow;
  } blss_out_t;

  typedef struct packed {
    logic rd;
    logic mac;
    logic wr_zero;
  } blss_ring_ctl_t;

endpackage

/* rtl/core/band_limited_step_synth_top.sv */
// ----------------------------------------------------------------------------
// band_limited_step_synth_top
// Band-limited step resampler with leaky integrator output.
// ----------------------------------------------------------------------------
// Input words carry an opcode: coefficient write, sample push or output read.
// Every accepted input word gives exactly one result word on the out channel.
// Both channels are valid/ready; in_ready is high only while idle.
// Path from input accept to the output register that holds the result:
//   coefficient write, unchanged push, dropped push, unused opcode: direct
//   push with a changed sample: one tap per cycle through the
//     single multiply-accumulate pipeline on the ring's read/write port
//   output read: ring read, then integrate and clamp (direct if avail is 0)
// The next word is taken the cycle after the result is registered.
// After reset all BUF_SAMPLES + TAPS ring entries are zeroed one entry per
// cycle, while in_ready stays low.
// A stalled receiver holds the result in the output register; the block
// takes one more word; its result waits in the output state until release.
// ----------------------------------------------------------------------------
module band_limited_step_synth_top import blss_pkg::*; #(
  parameter int TAPS        = TAPS_DEF,
  parameter int PHASES      = PHASES_DEF,
  parameter int BUF_SAMPLES = BUF_SAMPLES_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  blss_in_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output blss_out_t out_data
);

  localparam int RING = BUF_SAMPLES + TAPS;
  localparam int RW   = $clog2(RING);
  localparam int AW   = $clog2(BUF_SAMPLES + 1);
  localparam int FW   = $clog2(PHASES);
  localparam int CW   = $clog2(TAPS + 2);

  typedef enum logic [5:0] {
    ST_CLEAR = 6'b000001,
    ST_IDLE  = 6'b000010,
    ST_MAC   = 6'b000100,
    ST_RDA   = 6'b001000,
    ST_RDB   = 6'b010000,
    ST_OUT   = 6'b100000
  } state_t;

  state_t             state_r, state_nxt;
  logic [AW-1:0]      avail_r, avail_nxt;
  logic [FW-1:0]      frac_r, frac_nxt;
  logic [RW-1:0]      rp_r, rp_nxt;
  logic [RW-1:0]      ring_addr_r, ring_addr_nxt;
  logic signed [15:0] prev_r, prev_nxt;
  logic [31:0]        integ_r, integ_nxt;
  logic               out_valid_r, out_valid_nxt;
  blss_out_t          out_data_r, out_data_nxt;
  logic signed [16:0] delta_r, delta_nxt;
  logic [COEF_AW-1:0] coef_addr_r, coef_addr_nxt;
  logic [CW-1:0]      cnt_r, cnt_nxt;
  logic signed [15:0] res_sample_r, res_sample_nxt;
  logic               res_ovf_r, res_ovf_nxt;

  logic               accept;
  logic               issue;
  blss_ring_ctl_t     ring_ctl;
  logic [RW-1:0]      ring_rd_addr;
  logic [RW-1:0]      ring_wr_addr;
  logic [31:0]        acc_q;
  logic signed [15:0] coef_q;

  logic [AW:0]        t_new;
  logic [FW-1:0]      f_new;
  logic               push_ovf;
  logic [RW:0]        ring_sum;
  logic [RW-1:0]      ring_base;
  logic [31:0]        coef_full;
  logic [31:0]        sum1;
  logic [31:0]        sum_rnd;
  logic [16:0]        q17;
  logic [31:0]        avail_ext;

  assign accept = in_valid && in_ready;
  assign issue  = (state_r == ST_MAC) && (cnt_r < CW'(TAPS));

  // phase bookkeeping: avail is ceil(phase / PHASES), frac the remainder gap
  always_comb begin
    if (frac_r == '0) begin
      t_new = {1'b0, avail_r} + (AW+1)'(1);
      f_new = FW'(PHASES - 1);
    end else begin
      t_new = {1'b0, avail_r};
      f_new = frac_r - FW'(1);
    end
    push_ovf  = t_new > (AW+1)'(BUF_SAMPLES);
    ring_sum  = (RW+1)'(rp_r) + (RW+1)'(t_new);
    ring_base = (ring_sum >= (RW+1)'(RING)) ? RW'(ring_sum - (RW+1)'(RING))
                                            : ring_sum[RW-1:0];
    coef_full = 32'(f_new) * 32'(TAPS);
  end

  // leaky integrator with rounding
  always_comb begin
    sum1    = integ_r + {acc_q[31], acc_q[31:1]}
              - {{LEAK_SHIFT{integ_r[31]}}, integ_r[31:LEAK_SHIFT]};
    sum_rnd = sum1 + ROUND_HALF;
    q17     = sum_rnd[31:OUT_SHIFT];
  end

  assign avail_ext = 32'(avail_r);

  always_comb begin
    state_nxt      = state_r;
    avail_nxt      = avail_r;
    frac_nxt       = frac_r;
    rp_nxt         = rp_r;
    ring_addr_nxt  = ring_addr_r;
    prev_nxt       = prev_r;
    integ_nxt      = integ_r;
    out_valid_nxt  = out_valid_r;
    out_data_nxt   = out_data_r;
    delta_nxt      = delta_r;
    coef_addr_nxt  = coef_addr_r;
    cnt_nxt        = cnt_r;
    res_sample_nxt = res_sample_r;
    res_ovf_nxt    = res_ovf_r;

    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      ST_CLEAR: begin
        if (ring_addr_r == RW'(RING - 1)) begin
          ring_addr_nxt = '0;
          state_nxt     = ST_IDLE;
        end else begin
          ring_addr_nxt = ring_addr_r + RW'(1);
        end
      end
      ST_IDLE: begin
        if (accept) begin
          res_sample_nxt = '0;
          res_ovf_nxt    = 1'b0;
          state_nxt      = ST_OUT;
          case (in_data.opcode)
            OP_PUSH: begin
              if (push_ovf) begin
                res_ovf_nxt = 1'b1;
              end else begin
                avail_nxt = t_new[AW-1:0];
                frac_nxt  = f_new;
                if (in_data.sample_in != prev_r) begin
                  delta_nxt     = 17'(in_data.sample_in) - 17'(prev_r);
                  prev_nxt      = in_data.sample_in;
                  ring_addr_nxt = ring_base;
                  coef_addr_nxt = coef_full[COEF_AW-1:0];
                  cnt_nxt       = '0;
                  state_nxt     = ST_MAC;
                end
              end
            end
            OP_READ: begin
              if (avail_r != '0) begin
                state_nxt = ST_RDA;
              end
            end
            default: ;
          endcase
        end
      end
      ST_MAC: begin
        cnt_nxt = cnt_r + CW'(1);
        if (issue) begin
          ring_addr_nxt = (ring_addr_r == RW'(RING - 1)) ? '0 : ring_addr_r + RW'(1);
          coef_addr_nxt = coef_addr_r + COEF_AW'(1);
        end
        if (cnt_r == CW'(TAPS + 1)) begin
          state_nxt = ST_OUT;
        end
      end
      ST_RDA: begin
        state_nxt = ST_RDB;
      end
      ST_RDB: begin
        if (q17[16] != q17[15]) begin
          res_sample_nxt = q17[16] ? SAT_NEG : SAT_POS;
          integ_nxt      = q17[16] ? SAT_NEG_SUM : SAT_POS_SUM;
        end else begin
          res_sample_nxt = q17[15:0];
          integ_nxt      = sum1;
        end
        rp_nxt    = (rp_r == RW'(RING - 1)) ? '0 : rp_r + RW'(1);
        avail_nxt = avail_r - AW'(1);
        state_nxt = ST_OUT;
      end
      ST_OUT: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt            = 1'b1;
          out_data_nxt.sample_out  = res_sample_r;
          out_data_nxt.avail_count = avail_ext[11:0];
          out_data_nxt.overflow    = res_ovf_r;
          state_nxt                = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      avail_r     <= '0;
      frac_r      <= '0;
      rp_r        <= '0;
      ring_addr_r <= '0;
      prev_r      <= '0;
      integ_r     <= '0;
      out_valid_r <= 1'b0;
      cnt_r       <= '0;
    end else begin
      state_r     <= state_nxt;
      avail_r     <= avail_nxt;
      frac_r      <= frac_nxt;
      rp_r        <= rp_nxt;
      ring_addr_r <= ring_addr_nxt;
      prev_r      <= prev_nxt;
      integ_r     <= integ_nxt;
      out_valid_r <= out_valid_nxt;
      cnt_r       <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r   <= out_data_nxt;
    delta_r      <= delta_nxt;
    coef_addr_r  <= coef_addr_nxt;
    res_sample_r <= res_sample_nxt;
    res_ovf_r    <= res_ovf_nxt;
  end

  assign ring_ctl.rd      = issue || (state_r == ST_RDA);
  assign ring_ctl.mac     = (state_r == ST_MAC);
  assign ring_ctl.wr_zero = (state_r == ST_CLEAR) || (state_r == ST_RDB);
  assign ring_rd_addr     = (state_r == ST_MAC) ? ring_addr_r : rp_r;
  assign ring_wr_addr     = (state_r == ST_CLEAR) ? ring_addr_r : rp_r;

  blss_coef_mem u_coef (
    .clk     (clk),
    .wr_en   (accept && (in_data.opcode == OP_WR_COEF)),
    .wr_addr (in_data.coef_index),
    .wr_data (in_data.coef_value),
    .rd_en   (issue),
    .rd_addr (coef_addr_r),
    .rd_data (coef_q)
  );

  blss_ring #(
    .DEPTH (RING)
  ) u_ring (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctl     (ring_ctl),
    .rd_addr (ring_rd_addr),
    .wr_addr (ring_wr_addr),
    .delta   (delta_r),
    .coef    (coef_q),
    .acc_q   (acc_q)
  );

  assign in_ready  = (state_r == ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

/* rtl/core/blss_coef_mem.sv */
// ----------------------------------------------------------------------------
// blss_coef_mem
// Polyphase filter bank storage, one write and one registered read port.
// ----------------------------------------------------------------------------
module blss_coef_mem import blss_pkg::*; (
  input  logic                clk,
  input  logic                wr_en,
  input  logic [COEF_AW-1:0]  wr_addr,
  input  logic signed [15:0]  wr_data,
  input  logic                rd_en,
  input  logic [COEF_AW-1:0]  rd_addr,
  output logic signed [15:0]  rd_data
);

  logic signed [15:0] mem [COEF_DEPTH];
  logic signed [15:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

/* rtl/core/blss_ring.sv */
// ----------------------------------------------------------------------------
// blss_ring
// Accumulation ring with the shared multiply-accumulate pipeline:
// read, multiply delta by coefficient, add and write back.
// ----------------------------------------------------------------------------
module blss_ring import blss_pkg::*; #(
  parameter int DEPTH = RING_DEPTH_DEF
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  blss_ring_ctl_t           ctl,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic signed [16:0]       delta,
  input  logic signed [15:0]       coef,
  output logic [31:0]              acc_q
);

  localparam int AW = $clog2(DEPTH);

  logic [31:0]        mem [DEPTH];
  logic [31:0]        acc_q_r;
  logic [31:0]        acc2_r;
  logic signed [32:0] prod_r;
  logic [AW-1:0]      a1_r;
  logic [AW-1:0]      a2_r;
  logic               v1_r;
  logic               v2_r;

  always_ff @(posedge clk) begin
    if (ctl.rd) begin
      acc_q_r <= mem[rd_addr];
      a1_r    <= rd_addr;
    end
    a2_r   <= a1_r;
    acc2_r <= acc_q_r;
    prod_r <= delta * coef;
    if (v2_r) begin
      mem[a2_r] <= acc2_r + prod_r[31:0];
    end else if (ctl.wr_zero) begin
      mem[wr_addr] <= '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else begin
      v1_r <= ctl.rd & ctl.mac;
      v2_r <= v1_r;
    end
  end

  assign acc_q = acc_q_r;

endmodule

/* rtl/core/blss_chk.sv */
// ----------------------------------------------------------------------------
// blss_chk
// Port-level checks for the band-limited step synthesizer, bound to the top.
// ----------------------------------------------------------------------------
module blss_chk import blss_pkg::*; (
  input logic      clk,
  input logic      rst_n,
  input logic      in_valid,
  input logic      in_ready,
  input blss_in_t  in_data,
  input logic      out_valid,
  input logic      out_ready,
  input blss_out_t out_data
);

  // held result word must not change while stalled
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result word changed under stall");

  // one word in flight: busy right after an accept
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("accepted a word while busy");

  // dropped push carries no sample
  a_ovf_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.overflow |-> out_data.sample_out == 16'sd0)
    else $error("overflow word with nonzero sample");

  // ring clear runs after reset
  a_clear: assert property (@(posedge clk)
    !rst_n |=> !in_ready && !out_valid)
    else $error("ready during reset clear");

endmodule

bind band_limited_step_synth_top blss_chk u_blss_chk (.*);
